FILE: hdl/swsi_pkg.sv
// ----------------------------------------------------------------------------
// swsi_pkg
// Shared types and constants for the stack with sorted insert.
// ----------------------------------------------------------------------------
package swsi_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // Operation codes carried by the mode field.
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_INSERT = 2'd3
  } mode_t;

  // Status codes returned with each result word.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_HOLD = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } swsi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } swsi_stat_t;

endpackage

FILE: hdl/swsi_ctrl.sv
// ----------------------------------------------------------------------------
// swsi_ctrl
// Handshake controller: accepts one command word and holds its result word
// until the receiver takes it.
// ----------------------------------------------------------------------------
module swsi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  swsi_pkg::swsi_stat_t dp_stat,
  output swsi_pkg::swsi_cmd_t  dp_cmd
);
  import swsi_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A new word is taken when the result register is free or being emptied.
  always_comb begin
    cmd_stall   = (state == ST_HOLD) && rsp_stall;
    rsp_valid   = (state == ST_HOLD);
    accept      = cmd_valid && !cmd_stall;
    dp_cmd.exec = accept;
    state_next  = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (!rsp_stall && !accept) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The status flags are informational here; an empty and full stack at
  // once cannot occur.
  logic unused_stat;
  assign unused_stat = dp_stat.empty & dp_stat.full;

endmodule

FILE: hdl/swsi_dp.sv
// ----------------------------------------------------------------------------
// swsi_dp
// Datapath: a row of stack cells with per-cell compare and shift, the entry
// counter and the result register.
// ----------------------------------------------------------------------------
module swsi_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swsi_pkg::swsi_cmd_t                   dp_cmd,
  output swsi_pkg::swsi_stat_t                  dp_stat,
  input  logic [1:0]                            mode,
  input  logic signed [swsi_pkg::DATA_W-1:0]    value,
  output logic signed [swsi_pkg::DATA_W-1:0]    result_value,
  output logic [1:0]                            status,
  output logic [swsi_pkg::CNT_W-1:0]            depth_used
);
  import swsi_pkg::*;

  logic signed [DATA_W-1:0] entries [STACK_DEPTH];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         cnt_dec;
  logic [IDX_W-1:0]         top_idx;
  logic [STACK_DEPTH-1:0]   held;
  logic [STACK_DEPTH-1:0]   not_greater;
  logic [STACK_DEPTH-1:0]   shift_up;
  logic                     is_write;
  logic                     is_insert;
  logic                     do_write;
  logic                     do_pop;
  logic                     empty;
  logic                     full;
  logic signed [DATA_W-1:0] rd_value;
  logic [1:0]               st_value;

  // Decode the operation and the stack limits.
  always_comb begin
    empty     = (count == '0);
    full      = (count == CNT_W'(STACK_DEPTH));
    is_insert = (mode == MODE_INSERT);
    is_write  = (mode == MODE_PUSH) || is_insert;
    do_write  = dp_cmd.exec && is_write && !full;
    do_pop    = dp_cmd.exec && (mode == MODE_POP) && !empty;
    cnt_dec   = count - 1'b1;
    top_idx   = cnt_dec[IDX_W-1:0];
    dp_stat.empty = empty;
    dp_stat.full  = full;
  end

  // Per-cell compare: which held cells do not exceed the new value.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cmp
    assign held[i]        = (CNT_W'(i) < count);
    assign not_greater[i] = held[i] && !(entries[i] > value);
    // A cell moves up when it and every held cell above it is greater.
    assign shift_up[i]    = is_insert && held[i] && ((not_greater >> i) == '0);
  end

  // Cell update: take the value, take the cell below, or keep.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic at_slot;
    logic from_below;
    if (i == 0) begin : g_bottom
      assign from_below = 1'b0;
      assign at_slot    = shift_up[i] || (count == CNT_W'(i));
    end else begin : g_upper
      assign from_below = shift_up[i-1];
      assign at_slot    = !shift_up[i-1] && (shift_up[i] || (count == CNT_W'(i)));
    end
    always_ff @(posedge clk) begin
      if (do_write) begin
        if (from_below) begin
          entries[i] <= entries[i-1 < 0 ? 0 : i-1];
        end else if (at_slot) begin
          entries[i] <= value;
        end
      end
    end
  end

  // Next count and result word.
  always_comb begin
    count_next = count;
    rd_value   = '0;
    st_value   = STATUS_OK;
    if (is_write) begin
      if (full) st_value = STATUS_FULL;
      else count_next = count + 1'b1;
    end else begin
      if (empty) begin
        st_value = STATUS_EMPTY;
      end else begin
        rd_value = entries[top_idx];
        if (mode == MODE_POP) count_next = cnt_dec;
      end
    end
  end

  // Entry counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_write || do_pop) begin
      count <= count_next;
    end
  end

  // Result register, loaded once per accepted word.
  always_ff @(posedge clk) begin
    if (dp_cmd.exec) begin
      result_value <= rd_value;
      status       <= st_value;
      depth_used   <= count_next;
    end
  end

endmodule

FILE: hdl/stack_with_sorted_insert.sv
// ----------------------------------------------------------------------------
// stack_with_sorted_insert
// Bounded LIFO stack of signed words with push, pop, peek and sorted insert.
// ----------------------------------------------------------------------------
// Usage:
//   The command channel (cmd_valid, cmd_stall, mode, value) carries one word
//   per operation; the response channel (rsp_valid, rsp_stall, result_value,
//   status, depth_used) returns exactly one word for each command.
//   Every operation, sorted insert included, completes in the cycle it is
//   accepted: all cells compare against the new value in parallel and the
//   greater run on top shifts up by one cell. The response word appears in the
//   cycle after acceptance. A single result register sits between the
//   channels, so one word per cycle is sustained while the receiver keeps
//   rsp_stall low.
//   When the receiver stalls, the response word holds and cmd_stall rises
//   until that word is taken; a new command is accepted in the same cycle
//   the pending word leaves.
//   Reset empties the stack (the entry count clears) and drops any pending
//   response. Pop or peek on an empty stack returns status empty and 0;
//   push or insert on a full stack returns status full and changes nothing.
// ----------------------------------------------------------------------------
module stack_with_sorted_insert (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [1:0]                         mode,
  input  logic signed [swsi_pkg::DATA_W-1:0] value,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic signed [swsi_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                         status,
  output logic [swsi_pkg::CNT_W-1:0]         depth_used
);
  import swsi_pkg::*;

  swsi_cmd_t  dp_cmd;
  swsi_stat_t dp_stat;

  // Handshake controller.
  swsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // Stack cells, counter and result register.
  swsi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .mode         (mode),
    .value        (value),
    .result_value (result_value),
    .status       (status),
    .depth_used   (depth_used)
  );

  // An accepted command always yields a response word in the next cycle.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> rsp_valid)
    else $error("accepted command produced no response");

  // A full status is only reported with the stack at capacity.
  a_full_depth: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == STATUS_FULL) |-> (depth_used == CNT_W'(STACK_DEPTH)))
    else $error("full status with stack not at capacity");

  // An empty status comes with zero depth and a zero value.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == STATUS_EMPTY) |-> (depth_used == '0 && result_value == '0))
    else $error("empty status with nonzero depth or value");

  // The reported depth never exceeds the capacity.
  a_depth_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (depth_used <= CNT_W'(STACK_DEPTH)))
    else $error("depth beyond capacity");

endmodule

FILE: dv/swsi_stack_checker.sv
// ----------------------------------------------------------------------------
// swsi_stack_checker
// Watches both channels of the stack with sorted insert, keeps a mirror of
// the stack, and compares every response word with the predicted reply.
// ----------------------------------------------------------------------------
module swsi_stack_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  logic                               cmd_stall,
  input  logic [1:0]                         mode,
  input  logic signed [swsi_pkg::DATA_W-1:0] value,
  input  logic                               rsp_valid,
  input  logic                               rsp_stall,
  input  logic signed [swsi_pkg::DATA_W-1:0] result_value,
  input  logic [1:0]                         status,
  input  logic [swsi_pkg::CNT_W-1:0]         depth_used,
  output int                                 mismatch_count,
  output int                                 replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import swsi_pkg::*;

  // One predicted response word.
  typedef struct packed {
    logic signed [DATA_W-1:0] rv;
    logic [1:0]               st;
    logic [CNT_W-1:0]         depth;
  } stack_reply_t;

  // Mirror of the stack contents; entry 0 is the bottom.
  logic signed [DATA_W-1:0] mirror_entries [STACK_DEPTH];
  int                       mirror_count;
  stack_reply_t             stack_replies_q [$];

  // Applies one operation to the mirror and returns the reply it produces.
  function automatic stack_reply_t apply_stack_op(input mode_t op,
                                                  input logic signed [DATA_W-1:0] v);
    stack_reply_t r;
    int           pos;
    r.rv = '0;
    r.st = STATUS_OK;
    case (op)
      MODE_PUSH, MODE_INSERT: begin
        if (mirror_count >= STACK_DEPTH) begin
          r.st = STATUS_FULL;
        end else begin
          pos = mirror_count;
          // Sorted insert slides below every strictly greater entry on top.
          if (op == MODE_INSERT) begin
            while (pos > 0 && mirror_entries[pos-1] > v) pos--;
            for (int i = mirror_count; i > pos; i--) mirror_entries[i] = mirror_entries[i-1];
          end
          mirror_entries[pos] = v;
          mirror_count++;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          r.st = STATUS_EMPTY;
        end else begin
          r.rv = mirror_entries[mirror_count-1];
          if (op == MODE_POP) mirror_count--;
        end
      end
    endcase
    r.depth = CNT_W'(mirror_count);
    return r;
  endfunction

  // Retire response words first, then predict for the command taken at this edge.
  always @(posedge clk) begin : watch_channels
    stack_reply_t want;
    if (rst) begin
      mirror_count = 0;
      stack_replies_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (stack_replies_q.size() == 0) begin
          $display("%0t: response word with none outstanding: value %0d status %0d depth %0d",
                   $time, result_value, status, depth_used);
          mismatch_count++;
        end else begin
          want = stack_replies_q.pop_front();
          if (result_value !== want.rv) begin
            $display("%0t: result_value mismatch: expected %0d, actual %0d",
                     $time, want.rv, result_value);
            mismatch_count++;
          end
          if (status !== want.st) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.st, status);
            mismatch_count++;
          end
          if (depth_used !== want.depth) begin
            $display("%0t: depth_used mismatch: expected %0d, actual %0d",
                     $time, want.depth, depth_used);
            mismatch_count++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        stack_replies_q.push_back(apply_stack_op(mode_t'(mode), value));
      end
    end
    replies_owed = stack_replies_q.size();
  end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed stack operations into the stack with sorted
// insert under random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swsi_pkg::*;

  localparam int RANDOM_WORDS     = 850;
  localparam int QUIET_LIMIT      = 1000;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 60;

  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cmd_valid;
  logic                     cmd_stall;
  logic [1:0]               mode;
  logic signed [DATA_W-1:0] value;
  logic                     rsp_valid;
  logic                     rsp_stall;
  logic signed [DATA_W-1:0] result_value;
  logic [1:0]               status;
  logic [CNT_W-1:0]         depth_used;

  int mismatch_count;
  int replies_owed;
  int quiet_cycles = 0;
  bit tx_no_gap = 1'b0;

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stack_with_sorted_insert uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .mode         (mode),
    .value        (value),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_value (result_value),
    .status       (status),
    .depth_used   (depth_used)
  );

  swsi_stack_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .mode           (mode),
    .value          (value),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .result_value   (result_value),
    .status         (status),
    .depth_used     (depth_used),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  // Offers one command word after a random gap; called and returns at a falling edge.
  task automatic send_word(input mode_t op, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    mode      <= op;
    value     <= v;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // Fill phases favor push and insert, drain phases favor pop and peek.
  function automatic mode_t pick_mode(input int fill_pct);
    if ($urandom_range(0, 99) < fill_pct) begin
      return ($urandom_range(0, 2) == 0) ? MODE_PUSH : MODE_INSERT;
    end
    return ($urandom_range(0, 1) == 0) ? MODE_POP : MODE_PEEK;
  endfunction

  // Small values make equal keys on insert common; extremes and full range mix in.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:          return VALUE_MAX;
      1:          return VALUE_MIN;
      2, 3, 4, 5: return int'($urandom_range(0, 16)) - 8;
      default:    return $urandom();
    endcase
  endfunction

  // Command side: reset, directed corner cases, then random phases.
  initial begin : stimulus
    int sent;
    int phase_len;
    int fill_pct;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    mode      = MODE_PUSH;
    value     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Read on an empty stack.
    send_word(MODE_POP, 32'sd5);
    send_word(MODE_PEEK, -32'sd5);
    // Extremes, equal keys on insert, and an insert that passes a run of entries.
    send_word(MODE_PUSH, VALUE_MAX);
    send_word(MODE_PUSH, VALUE_MIN);
    send_word(MODE_INSERT, 32'sd0);
    send_word(MODE_INSERT, 32'sd0);
    send_word(MODE_INSERT, VALUE_MIN);
    send_word(MODE_INSERT, -32'sd1);
    send_word(MODE_PEEK, '0);
    send_word(MODE_POP, '0);
    // Fill to the top, then push and insert on a full stack.
    repeat (STACK_DEPTH - 5) send_word(($urandom_range(0, 1) == 0) ? MODE_PUSH : MODE_INSERT,
                                       pick_value());
    send_word(MODE_PUSH, VALUE_MAX);
    send_word(MODE_INSERT, VALUE_MIN);
    send_word(MODE_PEEK, '0);
    send_word(MODE_POP, '0);

    // Random phases that swing the stack between empty and full.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      phase_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       fill_pct = 80;
        1:       fill_pct = 25;
        default: fill_pct = 50;
      endcase
      tx_no_gap = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        send_word(pick_mode(fill_pct), pick_value());
        sent++;
      end
    end
    cmd_valid <= 1'b0;

    // Drain the outstanding responses, then watch a few more cycles for strays.
    do @(negedge clk); while (replies_owed != 0);
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Response side: random stalls per word, bursts without stalls, one long hold.
  initial begin : response_sink
    int hold;
    int taken;
    bit rx_no_gap;
    rsp_stall = 1'b0;
    taken     = 0;
    rx_no_gap = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (taken % 40 == 0) rx_no_gap = ($urandom_range(0, 3) == 0);
      if (taken == LONG_HOLD_AT) begin
        hold = LONG_HOLD_CYCLES;
      end else if (rx_no_gap) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 10);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      @(negedge clk);
      taken++;
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

FILE: files.f
hdl/swsi_pkg.sv
hdl/swsi_ctrl.sv
hdl/swsi_dp.sv
hdl/stack_with_sorted_insert.sv
dv/swsi_stack_checker.sv
dv/tb_top.sv
